@@ hdl/ils_pkg.sv @@
// Shared types and constants for the indexed list store.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 11) ? CNT_W + 1 : 12;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 12;
  localparam int OP_W     = 3;
  localparam int LEN_W    = 11;

  typedef enum logic [OP_W-1:0] {
    OP_GET     = 3'd0,
    OP_INS_HD  = 3'd1,
    OP_INS_TL  = 3'd2,
    OP_INS_POS = 3'd3,
    OP_DEL     = 3'd4
  } op_t;

  // What the decoded request will do.
  typedef enum logic [2:0] {
    K_NONE,
    K_GET,
    K_GET_BAD,
    K_INS,
    K_DEL
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GET_WAIT,
    S_SHIFT_UP,
    S_PLACE,
    S_SHIFT_DN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_get;
    logic step_up;
    logic step_dn;
    logic write_val;
    logic inc;
    logic dec;
    logic respond;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  at_end;
  } status_t;

endpackage

`default_nettype wire

@@ hdl/indexed_list_store.sv @@
// Top level of the indexed list store: controller plus datapath.
// Depends on ils_pkg, ils_ctrl and ils_dp.
//
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with out_valid high, and it cannot be held
// off. The list lives in a 1024 x 32 single-write, single-read memory, and
// inserts and deletes move one stored word per cycle through it. A get goes
// through decode, a read wait and the response state, an ignored request
// from decode straight to the response; an insert or a delete walks the
// entries between its position and the tail first, so the worst case is a
// head insert into 1023 entries, set by the shifting walk over the memory
// port. Busy drops in the cycle the result is shown, so the next request
// may be taken then. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_store (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire  [ils_pkg::OP_W-1:0]         in_operation,
  input  wire  signed [ils_pkg::POS_W-1:0] in_position,
  input  wire  signed [ils_pkg::VAL_W-1:0] in_item_value,
  output logic                             out_valid,
  output logic signed [ils_pkg::VAL_W-1:0] out_read_value,
  output logic                             out_read_ok,
  output logic                             out_done_res,
  output logic [ils_pkg::LEN_W-1:0]        out_list_length
);

  ils_pkg::cmd_t    cmd;
  ils_pkg::status_t status;

  ils_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ils_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_read_ok     (out_read_ok),
    .out_done_res    (out_done_res),
    .out_list_length (out_list_length)
  );

endmodule

`default_nettype wire

@@ hdl/ils_ctrl.sv @@
// Controller state machine for the indexed list store.
// Depends on ils_pkg; drives the datapath through a cmd_t word.
`timescale 1ns / 1ps
`default_nettype none

module ils_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  ils_pkg::status_t status,
  output ils_pkg::cmd_t    cmd,
  output logic             busy
);

  ils_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ils_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ils_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ils_pkg::S_DECODE;
        end
      end
      ils_pkg::S_DECODE: begin
        case (status.kind)
          ils_pkg::K_GET: begin
            cmd.rd_get = 1'b1;
            state_nxt  = ils_pkg::S_GET_WAIT;
          end
          ils_pkg::K_INS: state_nxt = ils_pkg::S_SHIFT_UP;
          ils_pkg::K_DEL: state_nxt = ils_pkg::S_SHIFT_DN;
          default:        state_nxt = ils_pkg::S_RESP;
        endcase
      end
      ils_pkg::S_GET_WAIT: state_nxt = ils_pkg::S_RESP;
      ils_pkg::S_SHIFT_UP: begin
        // the last pending write drains in the cycle at_end shows
        if (status.at_end) begin
          state_nxt = ils_pkg::S_PLACE;
        end else begin
          cmd.step_up = 1'b1;
        end
      end
      ils_pkg::S_PLACE: begin
        cmd.write_val = 1'b1;
        cmd.inc       = 1'b1;
        state_nxt     = ils_pkg::S_RESP;
      end
      ils_pkg::S_SHIFT_DN: begin
        if (status.at_end) begin
          cmd.dec   = 1'b1;
          state_nxt = ils_pkg::S_RESP;
        end else begin
          cmd.step_dn = 1'b1;
        end
      end
      ils_pkg::S_RESP: begin
        cmd.respond = 1'b1;
        state_nxt   = ils_pkg::S_IDLE;
      end
      default: state_nxt = ils_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/ils_dp.sv @@
// Datapath for the indexed list store: entry memory, count, walk pointer
// and result registers. Depends on ils_pkg; steered by ils_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ils_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire  [ils_pkg::OP_W-1:0]         in_operation,
  input  wire  signed [ils_pkg::POS_W-1:0] in_position,
  input  wire  signed [ils_pkg::VAL_W-1:0] in_item_value,
  input  ils_pkg::cmd_t                    cmd,
  output ils_pkg::status_t                 status,
  output logic                             out_valid,
  output logic signed [ils_pkg::VAL_W-1:0] out_read_value,
  output logic                             out_read_ok,
  output logic                             out_done_res,
  output logic [ils_pkg::LEN_W-1:0]        out_list_length
);

  logic [ils_pkg::VAL_W-1:0]  mem [ils_pkg::CAPACITY];
  logic [ils_pkg::VAL_W-1:0]  rd_data_r;

  logic [ils_pkg::CNT_W-1:0]  count_r;
  logic [ils_pkg::ADDR_W-1:0] ptr_r, idx_r, wr_addr_r;
  logic [ils_pkg::VAL_W-1:0]  val_r;
  ils_pkg::kind_t             kind_r, kind_nxt;
  logic                       wr_pend_r;

  logic                       out_valid_r;
  logic [ils_pkg::VAL_W-1:0]  out_value_r;
  logic                       out_ok_r, out_done_r;
  logic [ils_pkg::LEN_W-1:0]  out_len_r;

  // request decode
  logic                       pos_neg, full;
  logic [ils_pkg::CMP_W-1:0]  pos_ext, cnt_ext;
  logic [ils_pkg::ADDR_W-1:0] idx_nxt, ptr_nxt, cnt_addr;
  logic                       in_range;

  assign pos_neg  = in_position[ils_pkg::POS_W-1];
  assign pos_ext  = ils_pkg::CMP_W'(in_position[ils_pkg::POS_W-2:0]);
  assign cnt_ext  = ils_pkg::CMP_W'(count_r);
  assign full     = (count_r == ils_pkg::CNT_W'(ils_pkg::CAPACITY));
  assign in_range = !pos_neg && (pos_ext < cnt_ext);
  assign cnt_addr = count_r[ils_pkg::ADDR_W-1:0];

  always_comb begin
    kind_nxt = ils_pkg::K_NONE;
    idx_nxt  = pos_ext[ils_pkg::ADDR_W-1:0];
    case (ils_pkg::op_t'(in_operation))
      ils_pkg::OP_GET: begin
        kind_nxt = in_range ? ils_pkg::K_GET : ils_pkg::K_GET_BAD;
      end
      ils_pkg::OP_INS_HD: begin
        idx_nxt = '0;
        if (!full) kind_nxt = ils_pkg::K_INS;
      end
      ils_pkg::OP_INS_TL: begin
        idx_nxt = cnt_addr;
        if (!full) kind_nxt = ils_pkg::K_INS;
      end
      ils_pkg::OP_INS_POS: begin
        // negative position means the head
        if (pos_neg) begin
          idx_nxt = '0;
          if (!full) kind_nxt = ils_pkg::K_INS;
        end else if (!full && pos_ext <= cnt_ext) begin
          kind_nxt = ils_pkg::K_INS;
        end
      end
      ils_pkg::OP_DEL: begin
        if (in_range) kind_nxt = ils_pkg::K_DEL;
      end
      default: kind_nxt = ils_pkg::K_NONE;
    endcase
  end

  // inserts walk down from the tail, others start at the position
  assign ptr_nxt = (kind_nxt == ils_pkg::K_INS) ? cnt_addr : idx_nxt;

  // walk termination
  logic [ils_pkg::CNT_W-1:0] ptr_up1;
  assign ptr_up1 = ils_pkg::CNT_W'(ptr_r) + ils_pkg::CNT_W'(1);

  always_comb begin
    status.kind   = kind_r;
    status.at_end = 1'b0;
    case (kind_r)
      ils_pkg::K_INS: status.at_end = (ptr_r == idx_r);
      ils_pkg::K_DEL: status.at_end = (ptr_up1 >= count_r);
      default:        status.at_end = 1'b1;
    endcase
  end

  // memory ports
  logic                       rd_en, wr_en;
  logic [ils_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic [ils_pkg::VAL_W-1:0]  wr_data;

  always_comb begin
    rd_en   = cmd.rd_get | cmd.step_up | cmd.step_dn;
    rd_addr = ptr_r;
    if (cmd.step_up) rd_addr = ptr_r - ils_pkg::ADDR_W'(1);
    if (cmd.step_dn) rd_addr = ptr_up1[ils_pkg::ADDR_W-1:0];
  end

  assign wr_en   = wr_pend_r | cmd.write_val;
  assign wr_addr = cmd.write_val ? idx_r : wr_addr_r;
  assign wr_data = cmd.write_val ? val_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      kind_r      <= ils_pkg::K_NONE;
    end else begin
      wr_pend_r   <= cmd.step_up | cmd.step_dn;
      out_valid_r <= cmd.respond;
      if (cmd.load) kind_r <= kind_nxt;
      if (cmd.inc) begin
        count_r <= count_r + ils_pkg::CNT_W'(1);
      end else if (cmd.dec) begin
        count_r <= count_r - ils_pkg::CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= idx_nxt;
      ptr_r <= ptr_nxt;
      val_r <= in_item_value;
    end else if (cmd.step_up) begin
      ptr_r <= ptr_r - ils_pkg::ADDR_W'(1);
    end else if (cmd.step_dn) begin
      ptr_r <= ptr_up1[ils_pkg::ADDR_W-1:0];
    end
    // shifted word lands one slot from where it was read
    if (cmd.step_up | cmd.step_dn) wr_addr_r <= ptr_r;
    if (cmd.respond) begin
      out_ok_r   <= (kind_r == ils_pkg::K_GET);
      out_done_r <= (kind_r == ils_pkg::K_INS) || (kind_r == ils_pkg::K_DEL);
      out_len_r  <= ils_pkg::LEN_W'(count_r);
      case (kind_r)
        ils_pkg::K_GET:     out_value_r <= rd_data_r;
        ils_pkg::K_GET_BAD: out_value_r <= '1;
        default:            out_value_r <= '0;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_value_r;
  assign out_read_ok     = out_ok_r;
  assign out_done_res    = out_done_r;
  assign out_list_length = out_len_r;

endmodule

`default_nettype wire

@@ hdl/ils_checker.sv @@
// Port-level checks for the indexed list store, bound to the top level.
// Depends on ils_pkg and indexed_list_store.
`timescale 1ns / 1ps
`default_nettype none

module ils_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              start,
  input wire                              busy,
  input wire                              out_valid,
  input wire                              out_read_ok,
  input wire                              out_done_res,
  input wire  [ils_pkg::LEN_W-1:0]        out_list_length
);

  // accepted word keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after accept");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_ok_vs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_ok |-> !out_done_res)
    else $error("read and change flagged together");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_list_length <= ils_pkg::LEN_W'(ils_pkg::CAPACITY)))
    else $error("list length beyond capacity");

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);

`default_nettype wire
